### hw/rtl/assert_macros.svh
// assertion macros used by the pgn lexer and move tracker core
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/pgn_lex_pkg.sv
// types, codes and character class functions of the pgn lexer
// no dependencies
`default_nettype none
package pgn_lex_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // event kinds
    localparam logic [1:0] EV_CONTENT = 2'd0;
    localparam logic [1:0] EV_TOKEN   = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    // token kinds
    localparam logic [3:0] TK_OPEN    = 4'd0;
    localparam logic [3:0] TK_CLOSE   = 4'd1;
    localparam logic [3:0] TK_IDENT   = 4'd2;
    localparam logic [3:0] TK_STRING  = 4'd3;
    localparam logic [3:0] TK_COMMENT = 4'd4;
    localparam logic [3:0] TK_MOVE    = 4'd5;
    localparam logic [3:0] TK_NUMBER  = 4'd6;
    localparam logic [3:0] TK_WHITE   = 4'd7;
    localparam logic [3:0] TK_BLACK   = 4'd8;
    localparam logic [3:0] TK_DRAW    = 4'd9;
    localparam logic [3:0] TK_STAR    = 4'd10;
    localparam logic [3:0] TK_BLANK   = 4'd11;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CHAR    = 3'd1;
    localparam logic [2:0] ERR_UNTERM  = 3'd2;
    localparam logic [2:0] ERR_ESCAPE  = 3'd3;
    localparam logic [2:0] ERR_NUMBER  = 3'd4;
    localparam logic [2:0] ERR_ORDER   = 3'd5;

    // sections
    localparam logic [1:0] SEC_HEADER = 2'd0;
    localparam logic [1:0] SEC_MOVES  = 2'd1;
    localparam logic [1:0] SEC_ENDED  = 2'd2;

    // header positions
    localparam logic [1:0] HP_OPEN   = 2'd0;
    localparam logic [1:0] HP_IDENT  = 2'd1;
    localparam logic [1:0] HP_STRING = 2'd2;
    localparam logic [1:0] HP_CLOSE  = 2'd3;

    // lexer states
    localparam logic [3:0] LX_IDLE      = 4'd0;
    localparam logic [3:0] LX_IDENT     = 4'd1;
    localparam logic [3:0] LX_STRING    = 4'd2;
    localparam logic [3:0] LX_ESCAPE    = 4'd3;
    localparam logic [3:0] LX_BRACE     = 4'd4;
    localparam logic [3:0] LX_LINE      = 4'd5;
    localparam logic [3:0] LX_MOVE      = 4'd6;
    localparam logic [3:0] LX_DIGITS    = 4'd7;
    localparam logic [3:0] LX_MIXED     = 4'd8;
    localparam logic [3:0] LX_AWAIT_DOT = 4'd9;
    localparam logic [3:0] LX_DOTS      = 4'd10;

    // result prefix matcher codes
    localparam logic [3:0] RM_NONE = 4'd0;
    localparam logic [3:0] RM_ONE  = 4'd1;
    localparam logic [3:0] RM_ZERO = 4'd4;
    localparam logic [3:0] RM_1_0  = 4'd3;
    localparam logic [3:0] RM_0_1  = 4'd6;
    localparam logic [3:0] RM_DRAW = 4'd12;

    // symbol: byte, or the end mark in bit 8
    localparam logic [8:0] SYM_END = 9'h100;
    localparam logic [8:0] SYM_LF  = 9'h00A;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [3:0]  token_kind;
        logic [7:0]  content_byte;
        logic [15:0] move_number;
        logic        white_to_move;
        logic        in_move_section;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    function automatic logic is_digit(input logic [8:0] c);
        return c inside {[9'h030:9'h039]};
    endfunction

    function automatic logic is_ident_start(input logic [8:0] c);
        return c inside {[9'h061:9'h07A], [9'h041:9'h05A], 9'h05F};
    endfunction

    // P N B R Q K a-h O x
    function automatic logic is_move_start(input logic [8:0] c);
        return c inside {9'h050, 9'h04E, 9'h042, 9'h052, 9'h051, 9'h04B,
                         [9'h061:9'h068], 9'h04F, 9'h078};
    endfunction

    // start set plus 1-8 - =
    function automatic logic is_move_body(input logic [8:0] c);
        return is_move_start(c) || (c inside {[9'h031:9'h038], 9'h02D, 9'h03D});
    endfunction

    // digits / -
    function automatic logic is_number_char(input logic [8:0] c);
        return is_digit(c) || (c inside {9'h02F, 9'h02D});
    endfunction

    // prefix automaton over 1-0, 0-1, 1/2-1/2
    function automatic logic [3:0] match_next(input logic [3:0] m, input logic [8:0] c);
        logic [3:0] r;
        r = RM_NONE;
        case (m)
            4'd1: begin
                if (c == 9'h02D) r = 4'd2;
                else if (c == 9'h02F) r = 4'd7;
            end
            4'd2:  if (c == 9'h030) r = 4'd3;
            4'd4:  if (c == 9'h02D) r = 4'd5;
            4'd5:  if (c == 9'h031) r = 4'd6;
            4'd7:  if (c == 9'h032) r = 4'd8;
            4'd8:  if (c == 9'h02D) r = 4'd9;
            4'd9:  if (c == 9'h031) r = 4'd10;
            4'd10: if (c == 9'h02F) r = 4'd11;
            4'd11: if (c == 9'h032) r = 4'd12;
            default: r = RM_NONE;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/pgn_in_if.sv
// input channel: text byte or end mark with valid/ready
// no dependencies
`default_nettype none
interface pgn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

### hw/rtl/pgn_out_if.sv
// output channel: one lexer result item with valid/ready
// no dependencies
`default_nettype none
interface pgn_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [3:0]  token_kind;
    logic [7:0]  content_byte;
    logic [15:0] move_number;
    logic        white_to_move;
    logic        in_move_section;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output event_kind, output token_kind,
                    output content_byte, output move_number, output white_to_move,
                    output in_move_section, output error_code, output last,
                    input ready);
    modport sink (input valid, input event_kind, input token_kind,
                  input content_byte, input move_number, input white_to_move,
                  input in_move_section, input error_code, input last,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/pgn_lex_step.sv
// lexer state and the per-item next-state and result logic
// depends on pgn_lex_pkg
`default_nettype none
module pgn_lex_step #(
    parameter int NUMBER_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire [7:0]                i_text_byte,
    input  wire                      i_end_of_text,
    output pgn_lex_pkg::t_result     o_res [3],
    output logic [1:0]               o_res_cnt
);

    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    logic [1:0]             r_sec, sec;
    logic [3:0]             r_lx, lx;
    logic                   r_acr, acr;
    logic                   r_anl, anl;
    logic [1:0]             r_hp, hp;
    logic [NUMBER_BITS-1:0] r_acc, acc;
    logic [3:0]             r_rm, rm;
    logic [1:0]             r_pc, pc;
    logic [NUMBER_BITS-1:0] r_ctr, ctr;
    logic                   r_ws, ws;
    logic [2:0]             r_err, err;

    pgn_lex_pkg::t_result   res [3];
    logic [1:0]             n;
    logic [8:0]             c;
    logic                   do_idle;
    logic [NUMBER_BITS+3:0] acc10;

    function automatic pgn_lex_pkg::t_result mk(input logic [1:0] kind,
            input logic [3:0] tok, input logic [7:0] b,
            input logic [NUMBER_BITS-1:0] mc, input logic w,
            input logic [1:0] s, input logic [2:0] e);
        pgn_lex_pkg::t_result r;
        r.event_kind      = kind;
        r.token_kind      = tok;
        r.content_byte    = b;
        r.move_number     = (32'(mc) > 32'h0000FFFF) ? 16'hFFFF : 16'(32'(mc));
        r.white_to_move   = w;
        r.in_move_section = (s == pgn_lex_pkg::SEC_MOVES);
        r.error_code      = e;
        r.last            = 1'b0;
        return r;
    endfunction

    always_comb begin
        sec = r_sec; lx = r_lx; acr = r_acr; anl = r_anl; hp = r_hp;
        acc = r_acc; rm = r_rm; pc = r_pc; ctr = r_ctr; ws = r_ws; err = r_err;
        n = 2'd0;
        res[0] = '0; res[1] = '0; res[2] = '0;
        do_idle = 1'b0;
        c = {1'b0, i_text_byte};
        acc10 = '0;
        if (i_valid) begin
            if (err != pgn_lex_pkg::ERR_NONE) begin
                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                n = n + 2'd1;
            end else if (sec == pgn_lex_pkg::SEC_ENDED) begin
                res[n] = mk(pgn_lex_pkg::EV_END, 4'd0, 8'd0, ctr, ws, sec, err);
                n = n + 2'd1;
            end else begin
                if (i_end_of_text) begin
                    acr = 1'b0;
                    c = pgn_lex_pkg::SYM_END;
                end else if (acr && c == pgn_lex_pkg::SYM_LF) begin
                    // line feed after carriage return is dropped
                    acr = 1'b0;
                    c = 9'h1FF;
                end else begin
                    acr = (c == 9'h00D);
                    if (c == 9'h00D) c = pgn_lex_pkg::SYM_LF;
                end
                if (c != 9'h1FF) begin
                    case (lx)
                        pgn_lex_pkg::LX_IDENT: begin
                            if (pgn_lex_pkg::is_ident_start(c) || pgn_lex_pkg::is_digit(c)) begin
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_IDENT,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_IDENT,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                hp = pgn_lex_pkg::HP_STRING;
                                lx = pgn_lex_pkg::LX_IDLE;
                                do_idle = 1'b1;
                            end
                        end
                        pgn_lex_pkg::LX_STRING: begin
                            if (c == pgn_lex_pkg::SYM_END) begin
                                err = pgn_lex_pkg::ERR_UNTERM;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else if (c == 9'h022) begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_STRING,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                hp = pgn_lex_pkg::HP_CLOSE;
                                lx = pgn_lex_pkg::LX_IDLE;
                            end else if (c == 9'h05C) begin
                                lx = pgn_lex_pkg::LX_ESCAPE;
                            end else begin
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_STRING,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_ESCAPE: begin
                            if (c == pgn_lex_pkg::SYM_END) begin
                                err = pgn_lex_pkg::ERR_UNTERM;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else if (c == 9'h06E || c == 9'h074 || c == 9'h05C
                                         || c == 9'h022) begin
                                if (c == 9'h06E) c = 9'h00A;
                                else if (c == 9'h074) c = 9'h009;
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_STRING,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                                lx = pgn_lex_pkg::LX_STRING;
                            end else begin
                                err = pgn_lex_pkg::ERR_ESCAPE;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_BRACE: begin
                            if (c == pgn_lex_pkg::SYM_END) begin
                                err = pgn_lex_pkg::ERR_UNTERM;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else if (c == 9'h07D) begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_COMMENT,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                lx = pgn_lex_pkg::LX_IDLE;
                            end else begin
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_COMMENT,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_LINE: begin
                            if (c == pgn_lex_pkg::SYM_END || c == pgn_lex_pkg::SYM_LF) begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_COMMENT,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                lx = pgn_lex_pkg::LX_IDLE;
                                do_idle = 1'b1;
                            end else begin
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_COMMENT,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_MOVE: begin
                            if (pgn_lex_pkg::is_move_body(c)) begin
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_MOVE,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else begin
                                // token end reports the side that moved
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_MOVE,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                ws = ~ws;
                                lx = pgn_lex_pkg::LX_IDLE;
                                do_idle = 1'b1;
                            end
                        end
                        pgn_lex_pkg::LX_DIGITS, pgn_lex_pkg::LX_MIXED: begin
                            if (pgn_lex_pkg::is_number_char(c)) begin
                                rm = pgn_lex_pkg::match_next(rm, c);
                                if (!pgn_lex_pkg::is_digit(c)) begin
                                    lx = pgn_lex_pkg::LX_MIXED;
                                end else if (lx == pgn_lex_pkg::LX_DIGITS) begin
                                    acc10 = ((NUMBER_BITS+4)'(acc) << 3) + ((NUMBER_BITS+4)'(acc) << 1)
                                            + (NUMBER_BITS+4)'(c[3:0]);
                                    acc = (acc10 > (NUMBER_BITS+4)'(NUM_MAX)) ? NUM_MAX
                                          : acc10[NUMBER_BITS-1:0];
                                end
                            end else if (rm == pgn_lex_pkg::RM_1_0 || rm == pgn_lex_pkg::RM_0_1
                                         || rm == pgn_lex_pkg::RM_DRAW) begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN,
                                            (rm == pgn_lex_pkg::RM_1_0) ? pgn_lex_pkg::TK_WHITE :
                                            (rm == pgn_lex_pkg::RM_0_1) ? pgn_lex_pkg::TK_BLACK :
                                            pgn_lex_pkg::TK_DRAW,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                rm = pgn_lex_pkg::RM_NONE;
                                lx = pgn_lex_pkg::LX_IDLE;
                                do_idle = 1'b1;
                            end else if (lx == pgn_lex_pkg::LX_DIGITS && c == 9'h02E) begin
                                pc = 2'd1;
                                lx = pgn_lex_pkg::LX_DOTS;
                            end else if (lx == pgn_lex_pkg::LX_DIGITS && c == 9'h020) begin
                                lx = pgn_lex_pkg::LX_AWAIT_DOT;
                            end else begin
                                err = pgn_lex_pkg::ERR_NUMBER;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_AWAIT_DOT: begin
                            if (c == 9'h02E) begin
                                pc = 2'd1;
                                lx = pgn_lex_pkg::LX_DOTS;
                            end else if (c != 9'h020) begin
                                err = pgn_lex_pkg::ERR_NUMBER;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                        pgn_lex_pkg::LX_DOTS: begin
                            if (c == 9'h02E) begin
                                if (pc != 2'd3) pc = pc + 2'd1;
                            end else begin
                                // one period means white to move
                                ctr = acc;
                                ws = (pc == 2'd1);
                                pc = 2'd0;
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_NUMBER,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                                lx = pgn_lex_pkg::LX_IDLE;
                                do_idle = 1'b1;
                            end
                        end
                        default: begin
                            lx = pgn_lex_pkg::LX_IDLE;
                            do_idle = 1'b1;
                        end
                    endcase

                    if (do_idle) begin
                        if (c == pgn_lex_pkg::SYM_LF) begin
                            if (!anl) begin
                                anl = 1'b1;
                            end else begin
                                anl = 1'b0;
                                if (sec == pgn_lex_pkg::SEC_HEADER && hp != pgn_lex_pkg::HP_OPEN) begin
                                    err = pgn_lex_pkg::ERR_ORDER;
                                    lx = pgn_lex_pkg::LX_IDLE;
                                    res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end else begin
                                    if (sec == pgn_lex_pkg::SEC_HEADER) begin
                                        sec = pgn_lex_pkg::SEC_MOVES;
                                    end else begin
                                        // game over, back to a fresh header
                                        sec = pgn_lex_pkg::SEC_HEADER;
                                        hp = pgn_lex_pkg::HP_OPEN;
                                        ctr = NUMBER_BITS'(1);
                                        ws = 1'b1;
                                    end
                                    res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_BLANK,
                                                8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end
                            end
                        end else begin
                            anl = 1'b0;
                            if (c == 9'h020) begin
                                anl = 1'b0;
                            end else if (c == pgn_lex_pkg::SYM_END) begin
                                if (sec == pgn_lex_pkg::SEC_HEADER && hp != pgn_lex_pkg::HP_OPEN) begin
                                    err = pgn_lex_pkg::ERR_UNTERM;
                                    lx = pgn_lex_pkg::LX_IDLE;
                                    res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end else begin
                                    sec = pgn_lex_pkg::SEC_ENDED;
                                    res[n] = mk(pgn_lex_pkg::EV_END, 4'd0, 8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end
                            end else if (c == 9'h03B) begin
                                lx = pgn_lex_pkg::LX_LINE;
                            end else if (c == 9'h07B) begin
                                lx = pgn_lex_pkg::LX_BRACE;
                            end else if (sec == pgn_lex_pkg::SEC_HEADER) begin
                                if (c == 9'h05B && hp == pgn_lex_pkg::HP_OPEN) begin
                                    hp = pgn_lex_pkg::HP_IDENT;
                                    res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_OPEN,
                                                8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end else if (c == 9'h05D && hp == pgn_lex_pkg::HP_CLOSE) begin
                                    hp = pgn_lex_pkg::HP_OPEN;
                                    res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_CLOSE,
                                                8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end else if (c == 9'h022 && hp == pgn_lex_pkg::HP_STRING) begin
                                    lx = pgn_lex_pkg::LX_STRING;
                                end else if (pgn_lex_pkg::is_ident_start(c)
                                             && hp == pgn_lex_pkg::HP_IDENT) begin
                                    lx = pgn_lex_pkg::LX_IDENT;
                                    res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_IDENT,
                                                c[7:0], ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end else begin
                                    // header token in the wrong place, or a stray byte
                                    err = (c == 9'h05B || c == 9'h05D || c == 9'h022
                                           || pgn_lex_pkg::is_ident_start(c))
                                          ? pgn_lex_pkg::ERR_ORDER : pgn_lex_pkg::ERR_CHAR;
                                    lx = pgn_lex_pkg::LX_IDLE;
                                    res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                    n = n + 2'd1;
                                end
                            end else if (c == 9'h02A) begin
                                res[n] = mk(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_STAR,
                                            8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else if (pgn_lex_pkg::is_digit(c)) begin
                                lx = pgn_lex_pkg::LX_DIGITS;
                                acc = NUMBER_BITS'(c[3:0]);
                                rm = (c == 9'h031) ? pgn_lex_pkg::RM_ONE
                                   : (c == 9'h030) ? pgn_lex_pkg::RM_ZERO : pgn_lex_pkg::RM_NONE;
                            end else if (pgn_lex_pkg::is_move_start(c)) begin
                                lx = pgn_lex_pkg::LX_MOVE;
                                res[n] = mk(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_MOVE,
                                            c[7:0], ctr, ws, sec, err);
                                n = n + 2'd1;
                            end else begin
                                // a lone period is out of order, anything else is bad
                                err = (c == 9'h02E) ? pgn_lex_pkg::ERR_ORDER : pgn_lex_pkg::ERR_CHAR;
                                lx = pgn_lex_pkg::LX_IDLE;
                                res[n] = mk(pgn_lex_pkg::EV_ERROR, 4'd0, 8'd0, ctr, ws, sec, err);
                                n = n + 2'd1;
                            end
                        end
                    end
                end
            end
            if (n != 2'd0) res[n - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= pgn_lex_pkg::SEC_HEADER;
            r_lx  <= pgn_lex_pkg::LX_IDLE;
            r_acr <= 1'b0;
            r_anl <= 1'b0;
            r_hp  <= pgn_lex_pkg::HP_OPEN;
            r_acc <= '0;
            r_rm  <= pgn_lex_pkg::RM_NONE;
            r_pc  <= 2'd0;
            r_ctr <= NUMBER_BITS'(1);
            r_ws  <= 1'b1;
            r_err <= pgn_lex_pkg::ERR_NONE;
        end else if (i_valid) begin
            r_sec <= sec;
            r_lx  <= lx;
            r_acr <= acr;
            r_anl <= anl;
            r_hp  <= hp;
            r_acc <= acc;
            r_rm  <= rm;
            r_pc  <= pc;
            r_ctr <= ctr;
            r_ws  <= ws;
            r_err <= err;
        end
    end

    assign o_res     = res;
    assign o_res_cnt = n;

endmodule
`default_nettype wire

### hw/rtl/pgn_lex_fifo.sv
// result queue: takes up to three items a cycle, hands out one
// depends on pgn_lex_pkg
`default_nettype none
module pgn_lex_fifo (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  pgn_lex_pkg::t_result                  i_push_data [3],
    input  wire [1:0]                             i_push_cnt,
    input  wire                                   i_pop,
    output pgn_lex_pkg::t_result                  o_head,
    output logic [pgn_lex_pkg::FIFO_AW:0]         o_count
);

    localparam int AW = pgn_lex_pkg::FIFO_AW;

    pgn_lex_pkg::t_result r_mem [pgn_lex_pkg::FIFO_DEPTH];
    logic [AW-1:0]        r_wr, r_rd;
    logic [AW:0]          r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push_cnt) r_mem[r_wr + AW'(k)] <= i_push_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push_cnt);
            r_rd    <= r_rd + AW'(i_pop);
            r_count <= r_count + (AW+1)'(i_push_cnt) - (AW+1)'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule
`default_nettype wire

### hw/rtl/pgn_lexer_and_move_tracker_core.sv
// pgn lexer and move tracker: one input item per cycle while the result queue has room, 0 to 2 result items each
// path from input accept to first result valid: input register, then lexer step writing the result queue
// throughput: one input item per cycle while results drain at one per cycle;
// the ready check on the result queue (8 deep) limits the input rate when items give two results
// reset: synchronous active low, lexer in header section, queue empty
// depends on pgn_lex_pkg, pgn_in_if, pgn_out_if, pgn_lex_step, pgn_lex_fifo, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pgn_lexer_and_move_tracker_core #(
    parameter int NUMBER_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pgn_in_if.sink     i_in,
    pgn_out_if.source  o_out
);

    logic                                 r_in_valid;
    logic [7:0]                           r_text_byte;
    logic                                 r_end_of_text;
    pgn_lex_pkg::t_result                 res [3];
    logic [1:0]                           res_cnt;
    pgn_lex_pkg::t_result                 head;
    logic [pgn_lex_pkg::FIFO_AW:0]        count;
    logic                                 pop;

    // room for the item in flight plus this one
    assign i_in.ready = (count <= (pgn_lex_pkg::FIFO_AW+1)'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in.valid && i_in.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_text_byte   <= i_in.text_byte;
            r_end_of_text <= i_in.end_of_text;
        end
    end

    pgn_lex_step #(.NUMBER_BITS(NUMBER_BITS)) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_text_byte   (r_text_byte),
        .i_end_of_text (r_end_of_text),
        .o_res         (res),
        .o_res_cnt     (res_cnt)
    );

    pgn_lex_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_data (res),
        .i_push_cnt  (res_cnt),
        .i_pop       (pop),
        .o_head      (head),
        .o_count     (count)
    );

    assign pop                   = o_out.valid && o_out.ready;
    assign o_out.valid           = (count != '0);
    assign o_out.event_kind      = head.event_kind;
    assign o_out.token_kind      = head.token_kind;
    assign o_out.content_byte    = head.content_byte;
    assign o_out.move_number     = head.move_number;
    assign o_out.white_to_move   = head.white_to_move;
    assign o_out.in_move_section = head.in_move_section;
    assign o_out.error_code      = head.error_code;
    assign o_out.last            = head.last;

    `ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n,
        count <= (pgn_lex_pkg::FIFO_AW+1)'(pgn_lex_pkg::FIFO_DEPTH))
    `ASSERT_IMPLY(a_error_has_code, i_clk, i_rst_n,
        res_cnt != 2'd0 && res[0].event_kind == pgn_lex_pkg::EV_ERROR,
        res[0].error_code != pgn_lex_pkg::ERR_NONE)
    `ASSERT_NEXT(a_ready_room, i_clk, i_rst_n, i_in.valid && i_in.ready,
        count <= (pgn_lex_pkg::FIFO_AW+1)'(5))

endmodule
`default_nettype wire

### tb/tb_pgn_lexer_and_move_tracker_core.sv
// testbench of the pgn lexer and move tracker core
// drives whole games byte by byte and checks every result item against a local lexer model
// depends on pgn_lex_pkg, pgn_in_if, pgn_out_if and pgn_lexer_and_move_tracker_core
`timescale 1ns / 1ps
module tb_pgn_lexer_and_move_tracker_core;

    localparam int END_MARK   = 256;
    localparam int CYCLE_MAX  = 400000;
    localparam int NUM_SAT    = 65535;
    localparam string START_CHARS = "PNBRQKabcdefghOx";
    localparam string BODY_CHARS  = "PNBRQKabcdefgh12345678xO-=";
    localparam string NUM_CHARS   = "0123456789/-";

    logic i_clk;
    logic i_rst_n;

    pgn_in_if  in_ch ();
    pgn_out_if res_ch ();

    pgn_lexer_and_move_tracker_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // lexer model state
    logic [1:0]  sec;
    logic [3:0]  lx;
    logic        after_cr;
    logic        after_nl;
    logic [1:0]  hdr_pos;
    int unsigned num_acc;
    logic [3:0]  res_match;
    logic [1:0]  dots;
    logic [15:0] move_cnt;
    logic        white;
    logic [2:0]  err;

    pgn_lex_pkg::t_result step_out[$];
    pgn_lex_pkg::t_result expected_results[$];

    int  mismatches;
    int  cycles;
    bit  quiet;
    int  long_hold;
    int  rx_stall;

    function automatic bit char_in(string s, int c);
        for (int i = 0; i < s.len(); i++)
            if (s[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit chr_digit(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit chr_ident(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // prefix automaton over 1-0, 0-1 and 1/2-1/2
    function automatic logic [3:0] result_prefix(logic [3:0] m, int c);
        case (m)
            4'd1:  return c == "-" ? 4'd2 : (c == "/" ? 4'd7 : pgn_lex_pkg::RM_NONE);
            4'd2:  return c == "0" ? pgn_lex_pkg::RM_1_0 : pgn_lex_pkg::RM_NONE;
            4'd4:  return c == "-" ? 4'd5 : pgn_lex_pkg::RM_NONE;
            4'd5:  return c == "1" ? pgn_lex_pkg::RM_0_1 : pgn_lex_pkg::RM_NONE;
            4'd7:  return c == "2" ? 4'd8 : pgn_lex_pkg::RM_NONE;
            4'd8:  return c == "-" ? 4'd9 : pgn_lex_pkg::RM_NONE;
            4'd9:  return c == "1" ? 4'd10 : pgn_lex_pkg::RM_NONE;
            4'd10: return c == "/" ? 4'd11 : pgn_lex_pkg::RM_NONE;
            4'd11: return c == "2" ? pgn_lex_pkg::RM_DRAW : pgn_lex_pkg::RM_NONE;
            default: return pgn_lex_pkg::RM_NONE;
        endcase
    endfunction

    task automatic put(logic [1:0] kind, logic [3:0] tok, int b);
        pgn_lex_pkg::t_result r;
        if (step_out.size() >= 3) return;
        r.event_kind      = kind;
        r.token_kind      = tok;
        r.content_byte    = b[7:0];
        r.move_number     = move_cnt;
        r.white_to_move   = white;
        r.in_move_section = sec == pgn_lex_pkg::SEC_MOVES;
        r.error_code      = err;
        r.last            = 1'b0;
        step_out = {step_out, r};
    endtask

    task automatic raise(logic [2:0] code);
        err = code;
        lx  = pgn_lex_pkg::LX_IDLE;
        put(pgn_lex_pkg::EV_ERROR, pgn_lex_pkg::TK_OPEN, 0);
    endtask

    task automatic between_tokens(int c);
        if (c == 10) begin
            if (!after_nl) begin
                after_nl = 1'b1;
                return;
            end
            after_nl = 1'b0;
            if (sec == pgn_lex_pkg::SEC_HEADER) begin
                if (hdr_pos != pgn_lex_pkg::HP_OPEN) begin
                    raise(pgn_lex_pkg::ERR_ORDER);
                    return;
                end
                sec = pgn_lex_pkg::SEC_MOVES;
            end else begin
                sec = pgn_lex_pkg::SEC_HEADER;
                hdr_pos = pgn_lex_pkg::HP_OPEN;
                move_cnt = 1;
                white = 1'b1;
            end
            put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_BLANK, 0);
            return;
        end
        after_nl = 1'b0;
        if (c == " ") return;
        if (c == END_MARK) begin
            if (sec == pgn_lex_pkg::SEC_HEADER && hdr_pos != pgn_lex_pkg::HP_OPEN) begin
                raise(pgn_lex_pkg::ERR_UNTERM);
                return;
            end
            sec = pgn_lex_pkg::SEC_ENDED;
            put(pgn_lex_pkg::EV_END, pgn_lex_pkg::TK_OPEN, 0);
            return;
        end
        if (c == ";") begin lx = pgn_lex_pkg::LX_LINE; return; end
        if (c == "{") begin lx = pgn_lex_pkg::LX_BRACE; return; end
        if (sec == pgn_lex_pkg::SEC_HEADER) begin
            if (c == "[") begin
                if (hdr_pos != pgn_lex_pkg::HP_OPEN) begin
                    raise(pgn_lex_pkg::ERR_ORDER);
                    return;
                end
                hdr_pos = pgn_lex_pkg::HP_IDENT;
                put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_OPEN, 0);
            end else if (c == "]") begin
                if (hdr_pos != pgn_lex_pkg::HP_CLOSE) begin
                    raise(pgn_lex_pkg::ERR_ORDER);
                    return;
                end
                hdr_pos = pgn_lex_pkg::HP_OPEN;
                put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_CLOSE, 0);
            end else if (c == "\"") begin
                if (hdr_pos != pgn_lex_pkg::HP_STRING) begin
                    raise(pgn_lex_pkg::ERR_ORDER);
                    return;
                end
                lx = pgn_lex_pkg::LX_STRING;
            end else if (chr_ident(c)) begin
                if (hdr_pos != pgn_lex_pkg::HP_IDENT) begin
                    raise(pgn_lex_pkg::ERR_ORDER);
                    return;
                end
                lx = pgn_lex_pkg::LX_IDENT;
                put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_IDENT, c);
            end else begin
                raise(pgn_lex_pkg::ERR_CHAR);
            end
            return;
        end
        if (c == "*") begin
            put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_STAR, 0);
        end else if (c == ".") begin
            raise(pgn_lex_pkg::ERR_ORDER);
        end else if (chr_digit(c)) begin
            lx = pgn_lex_pkg::LX_DIGITS;
            num_acc = c - "0";
            res_match = c == "1" ? pgn_lex_pkg::RM_ONE
                      : (c == "0" ? pgn_lex_pkg::RM_ZERO : pgn_lex_pkg::RM_NONE);
        end else if (char_in(START_CHARS, c)) begin
            lx = pgn_lex_pkg::LX_MOVE;
            put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_MOVE, c);
        end else begin
            raise(pgn_lex_pkg::ERR_CHAR);
        end
    endtask

    task automatic lex_char(int c);
        int e;
        case (lx)
            pgn_lex_pkg::LX_IDENT: begin
                if (chr_ident(c) || chr_digit(c)) begin
                    put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_IDENT, c);
                end else begin
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_IDENT, 0);
                    hdr_pos = pgn_lex_pkg::HP_STRING;
                    lx = pgn_lex_pkg::LX_IDLE;
                    between_tokens(c);
                end
            end
            pgn_lex_pkg::LX_STRING: begin
                if (c == END_MARK) raise(pgn_lex_pkg::ERR_UNTERM);
                else if (c == "\"") begin
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_STRING, 0);
                    hdr_pos = pgn_lex_pkg::HP_CLOSE;
                    lx = pgn_lex_pkg::LX_IDLE;
                end else if (c == "\\") lx = pgn_lex_pkg::LX_ESCAPE;
                else put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_STRING, c);
            end
            pgn_lex_pkg::LX_ESCAPE: begin
                e = c == "n" ? 10 : (c == "t" ? 9 : c);
                if (c == END_MARK) raise(pgn_lex_pkg::ERR_UNTERM);
                else if (c != "n" && c != "t" && c != "\\" && c != "\"")
                    raise(pgn_lex_pkg::ERR_ESCAPE);
                else begin
                    put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_STRING, e);
                    lx = pgn_lex_pkg::LX_STRING;
                end
            end
            pgn_lex_pkg::LX_BRACE: begin
                if (c == END_MARK) raise(pgn_lex_pkg::ERR_UNTERM);
                else if (c == "}") begin
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_COMMENT, 0);
                    lx = pgn_lex_pkg::LX_IDLE;
                end else put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_COMMENT, c);
            end
            pgn_lex_pkg::LX_LINE: begin
                if (c == END_MARK || c == 10) begin
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_COMMENT, 0);
                    lx = pgn_lex_pkg::LX_IDLE;
                    between_tokens(c);
                end else put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_COMMENT, c);
            end
            pgn_lex_pkg::LX_MOVE: begin
                if (char_in(BODY_CHARS, c)) begin
                    put(pgn_lex_pkg::EV_CONTENT, pgn_lex_pkg::TK_MOVE, c);
                end else begin
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_MOVE, 0);
                    white = ~white;
                    lx = pgn_lex_pkg::LX_IDLE;
                    between_tokens(c);
                end
            end
            pgn_lex_pkg::LX_DIGITS, pgn_lex_pkg::LX_MIXED: begin
                if (char_in(NUM_CHARS, c)) begin
                    res_match = result_prefix(res_match, c);
                    if (!chr_digit(c)) begin
                        lx = pgn_lex_pkg::LX_MIXED;
                    end else if (lx == pgn_lex_pkg::LX_DIGITS) begin
                        num_acc = num_acc * 10 + (c - "0");
                        if (num_acc > NUM_SAT) num_acc = NUM_SAT;
                    end
                end else if (res_match == pgn_lex_pkg::RM_1_0 || res_match == pgn_lex_pkg::RM_0_1
                             || res_match == pgn_lex_pkg::RM_DRAW) begin
                    put(pgn_lex_pkg::EV_TOKEN,
                        res_match == pgn_lex_pkg::RM_1_0 ? pgn_lex_pkg::TK_WHITE :
                        (res_match == pgn_lex_pkg::RM_0_1 ? pgn_lex_pkg::TK_BLACK
                                                          : pgn_lex_pkg::TK_DRAW), 0);
                    res_match = pgn_lex_pkg::RM_NONE;
                    lx = pgn_lex_pkg::LX_IDLE;
                    between_tokens(c);
                end else if (lx == pgn_lex_pkg::LX_DIGITS && c == ".") begin
                    dots = 1;
                    lx = pgn_lex_pkg::LX_DOTS;
                end else if (lx == pgn_lex_pkg::LX_DIGITS && c == " ") begin
                    lx = pgn_lex_pkg::LX_AWAIT_DOT;
                end else begin
                    raise(pgn_lex_pkg::ERR_NUMBER);
                end
            end
            pgn_lex_pkg::LX_AWAIT_DOT: begin
                if (c == ".") begin
                    dots = 1;
                    lx = pgn_lex_pkg::LX_DOTS;
                end else if (c != " ") raise(pgn_lex_pkg::ERR_NUMBER);
            end
            pgn_lex_pkg::LX_DOTS: begin
                if (c == ".") begin
                    if (dots < 3) dots++;
                end else begin
                    move_cnt = num_acc[15:0];
                    white = dots == 1;
                    dots = 0;
                    put(pgn_lex_pkg::EV_TOKEN, pgn_lex_pkg::TK_NUMBER, 0);
                    lx = pgn_lex_pkg::LX_IDLE;
                    between_tokens(c);
                end
            end
            default: begin
                lx = pgn_lex_pkg::LX_IDLE;
                between_tokens(c);
            end
        endcase
    endtask

    // works out the result items of one accepted input item
    task automatic predict_results(logic [7:0] b, logic eot);
        int c;
        step_out.delete();
        if (err != pgn_lex_pkg::ERR_NONE) begin
            put(pgn_lex_pkg::EV_ERROR, pgn_lex_pkg::TK_OPEN, 0);
        end else if (sec == pgn_lex_pkg::SEC_ENDED) begin
            put(pgn_lex_pkg::EV_END, pgn_lex_pkg::TK_OPEN, 0);
        end else if (eot) begin
            after_cr = 1'b0;
            lex_char(END_MARK);
        end else begin
            c = b;
            if (after_cr && c == 10) begin
                after_cr = 1'b0;
                return;
            end
            after_cr = c == 13;
            if (c == 13) c = 10;
            lex_char(c);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_results = {expected_results, step_out[i]};
    endtask

    task automatic send_item(logic [7:0] b, logic eot);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_results(b, eot);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic string pick(string s);
        int k;
        k = $urandom_range(0, s.len() - 1);
        return s.substr(k, k);
    endfunction

    function automatic string line_end();
        case ($urandom_range(0, 2))
            0: return "\n";
            1: return "\r\n";
            default: return "\r";
        endcase
    endfunction

    // any byte except zero and the ones that end or escape a string
    function automatic string free_byte(int stop);
        byte unsigned b;
        string s;
        do b = $urandom_range(0, 255); while (b == stop || b == "\\" || b == 0);
        s = " ";
        s[0] = b;
        return s;
    endfunction

    function automatic string make_header();
        string s;
        s = {"[", pick("abcdefghXYZ_")};
        repeat ($urandom_range(0, 4)) s = {s, pick("abzAZ_09")};
        s = {s, " \""};
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) s = {s, "\\", pick("nt\\\"")};
            else s = {s, free_byte("\"")};
        end
        return {s, "\"]", line_end()};
    endfunction

    function automatic string make_move();
        string s;
        s = pick(START_CHARS);
        repeat ($urandom_range(0, 5)) s = {s, pick(BODY_CHARS)};
        return s;
    endfunction

    // the second line end of a blank line is always cr lf so it never merges with the first
    function automatic string make_game();
        string s;
        int n;
        s = "";
        if ($urandom_range(0, 3) == 0) s = {"; ", pick("abcxyz!?"), line_end()};
        repeat ($urandom_range(1, 2)) s = {s, make_header()};
        s = {s, "\r\n"};
        n = $urandom_range(1, 4);
        for (int k = 1; k <= n; k++) begin
            case ($urandom_range(0, 5))
                0: s = {s, $sformatf("%0d", $urandom_range(0, 99999))};
                default: s = {s, $sformatf("%0d", k)};
            endcase
            if ($urandom_range(0, 3) == 0) s = {s, "  "};
            s = {s, ($urandom_range(0, 2) == 0) ? string'("...") : string'("."), " ",
                 make_move(), " "};
            if ($urandom_range(0, 3) == 0) s = {s, "{", free_byte("}"), free_byte("}"), "} "};
            if ($urandom_range(0, 1)) s = {s, make_move(), line_end()};
        end
        case ($urandom_range(0, 3))
            0: s = {s, "1-0"};
            1: s = {s, "0-1"};
            2: s = {s, "1/2-1/2"};
            default: s = {s, "*"};
        endcase
        return {s, line_end(), "\r\n"};
    endfunction

    // result checking
    always @(posedge i_clk) begin
        pgn_lex_pkg::t_result got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.event_kind      = res_ch.event_kind;
            got.token_kind      = res_ch.token_kind;
            got.content_byte    = res_ch.content_byte;
            got.move_number     = res_ch.move_number;
            got.white_to_move   = res_ch.white_to_move;
            got.in_move_section = res_ch.in_move_section;
            got.error_code      = res_ch.error_code;
            got.last            = res_ch.last;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold    <= long_hold - 1;
            res_ch.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall     <= rx_stall - 1;
            res_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall     <= $urandom_range(0, 12);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("pgn_lexer_and_move_tracker_core test failed");
            $finish;
        end
    end

    task automatic test_header();
        send_text("[Z_9 \"\\n\\t\\\\\\\"\xff\x80\"]\r\n\n");
    endtask

    task automatic test_moves();
        send_text("70000... Kx1 {}1 .e8=Q ;\xfe\r\r");
    endtask

    task automatic test_results();
        send_text("[a \"\"]\n\n0-1\n\n[a \"\"]\n\n1/2-1/2\n\n[a \"\"]\n\n1-0 *\n\n");
    endtask

    task automatic test_random_games();
        int sent;
        sent = 0;
        while (sent < 120) begin
            string g;
            g = make_game();
            send_text(g);
            sent += g.len();
        end
    endtask

    task automatic test_backpressure();
        string s;
        s = "[Long \"";
        repeat (40) s = {s, free_byte("\"")};
        s = {s, "\"]\n\n1. e4 e5 *\n\n"};
        long_hold = 300;
        send_text(s);
        drain();
    endtask

    // one sticky error or a clean end of input, then a few items after it
    task automatic test_error_and_end();
        quiet = 1'b1;
        case ($urandom_range(0, 6))
            0: send_text("#");
            1: begin send_text("[A \"ab"); send_end(); end
            2: send_text("[A \"\\q");
            3: send_text("[A \"b\"]\n\n12x");
            4: send_text("]");
            5: send_text("[A \"b\"]\n\n.");
            default: begin send_text("[A \"b\"]\n\n1. e4 "); send_end(); end
        endcase
        send_end();
        send_text("e4\n");
        send_end();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.text_byte    = 8'd0;
        in_ch.end_of_text  = 1'b0;
        mismatches = 0;
        cycles     = 0;
        quiet      = 1'b0;
        long_hold  = 0;
        rx_stall   = 0;
        sec = pgn_lex_pkg::SEC_HEADER;
        lx = pgn_lex_pkg::LX_IDLE;
        after_cr = 1'b0;
        after_nl = 1'b0;
        hdr_pos = pgn_lex_pkg::HP_OPEN;
        num_acc = 0;
        res_match = pgn_lex_pkg::RM_NONE;
        dots = 0;
        move_cnt = 1;
        white = 1'b1;
        err = pgn_lex_pkg::ERR_NONE;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header();
        test_moves();
        test_results();
        test_backpressure();
        test_random_games();
        test_error_and_end();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("pgn_lexer_and_move_tracker_core test passed");
        end else begin
            $display("pgn_lexer_and_move_tracker_core test failed");
        end
        $finish;
    end
endmodule
